// File: rtl/ppws_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the
// pure-pursuit waypoint steering unit. No dependencies.
`timescale 1ns / 1ps

package ppws_pkg;

    localparam int MAX_WAYPOINTS_DEF = 64;
    localparam int CordicSteps       = 30;
    localparam int SqrtSteps         = 32;
    localparam int DivSteps          = 30;
    localparam int XyW               = 36;
    localparam int ZW                = 34;

    localparam logic [31:0] WHEEL_BASE_RST    = 32'd163840;
    localparam logic [31:0] ARRIVE_RADIUS_RST = 32'd32768;
    localparam logic [6:0]  WP_COUNT_RST      = 7'd0;

    localparam logic signed [XyW-1:0] CORDIC_K  = 36'sd652032874;
    localparam logic signed [XyW-1:0] ONE_Q30   = 36'sd1073741824;
    localparam logic signed [ZW-1:0]  ANG_PI    = 34'sd2147483648;
    localparam logic signed [ZW-1:0]  ANG_HPI   = 34'sd1073741824;
    localparam logic signed [ZW-1:0]  ANG_QPI   = 34'sd536870912;
    localparam logic [13:0]           STEER_MAX = 14'd8192;

    typedef enum logic [1:0] {
        REG_WHEEL_BASE    = 2'd0,
        REG_ARRIVE_RADIUS = 2'd1,
        REG_WP_COUNT      = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    typedef enum logic {
        CM_VECTOR = 1'b0,
        CM_ROTATE = 1'b1
    } cordic_mode_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_DIFF, ST_ABS, ST_SQX, ST_SQY, ST_SQRT, ST_ARRIVE,
        ST_BEAR_GO, ST_BEAR_WAIT, ST_SINE_GO, ST_SINE_WAIT, ST_NUM, ST_DIVCHK,
        ST_DIV, ST_ATAN_GO, ST_ATAN_WAIT, ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] wheel_base;
        logic [31:0] arrive_radius;
        logic [6:0]  waypoint_count;
    } cfg_t;

    typedef struct packed {
        logic         start;
        cordic_mode_t mode;
    } cordic_ctl_t;

    typedef struct packed {
        logic        advanced;
        logic [6:0]  waypoint_index;
        logic        stop;
        logic [14:0] steering_angle;
    } result_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/ppws_table.sv
// Waypoint table: one write port, one registered read port.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module ppws_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [63:0]   rdata
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/ppws_cordic.sv
// Shared iterative CORDIC engine: vectoring or rotation, one step a cycle.
// Uses ppws_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module ppws_cordic
    import ppws_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cordic_ctl_t           ctl,
    input  logic signed [XyW-1:0] x0,
    input  logic signed [XyW-1:0] y0,
    input  logic signed [ZW-1:0]  z0,
    output logic                  done,
    output logic signed [XyW-1:0] x,
    output logic signed [XyW-1:0] y,
    output logic signed [ZW-1:0]  z
);

    logic signed [XyW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0]  z_reg;
    logic [4:0]            cnt_reg;
    logic                  run_reg, done_reg;
    cordic_mode_t          mode_reg;

    logic signed [XyW-1:0] xs, ys;
    logic signed [ZW-1:0]  t;
    logic                  down;

    always_comb begin
        xs   = x_reg >>> cnt_reg;
        ys   = y_reg >>> cnt_reg;
        t    = $signed({2'b00, atan_entry(cnt_reg)});
        down = (mode_reg == CM_VECTOR) ? (y_reg <= 0) : (z_reg >= 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(CordicSteps - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            x_reg    <= x0;
            y_reg    <= y0;
            z_reg    <= z0;
            mode_reg <= ctl.mode;
        end else if (run_reg) begin
            if (down) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - t;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + t;
            end
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;

endmodule

// File: rtl/ppws_core.sv
// Sequencer and datapath: distance, square root, division and steering law.
// Uses ppws_pkg and instantiates ppws_cordic; drives the waypoint table ports.
`timescale 1ns / 1ps

module ppws_core
    import ppws_pkg::*;
#(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF,
    parameter int AW            = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic          command,
    input  logic [31:0]   pos_x,
    input  logic [31:0]   pos_y,
    input  logic [15:0]   heading,
    input  logic [5:0]    load_index,
    input  logic [31:0]   load_x,
    input  logic [31:0]   load_y,
    input  cfg_t          cfg,
    output logic          idle,
    output logic          res_valid,
    output result_t       res,
    output logic          tbl_we,
    output logic [AW-1:0] tbl_waddr,
    output logic [63:0]   tbl_wdata,
    output logic [AW-1:0] tbl_raddr,
    input  logic [63:0]   tbl_rdata
);

    state_t state_reg, state_next;

    logic        cmd_reg;
    logic [31:0] px_reg, py_reg, lx_reg, ly_reg;
    logic [15:0] head_reg;
    logic [5:0]  lidx_reg;

    logic signed [32:0] dx_reg, dy_reg;
    logic [31:0] ax_reg, ay_reg;
    logic        half_reg;
    logic [63:0] sum_reg, sq_n_reg, sq_r_reg, sq_bit_reg;
    logic [4:0]  cnt_reg;
    logic [33:0] dist_reg;
    logic [31:0] err_reg;
    logic        neg_reg;
    logic [30:0] mag_reg;
    logic [63:0] num_reg, rem_reg, dsh_reg;
    logic [29:0] q_reg;

    logic [14:0] held_reg;
    logic [6:0]  cur_reg;
    logic        stop_reg, adv_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [6:0]  count_c;
    logic        slot_ok;
    logic [32:0] axf, ayf;
    logic [63:0] sq_t;
    logic [33:0] dist_c;
    logic        zero_vec;
    logic signed [ZW-1:0]  a_c;
    logic signed [XyW-1:0] s_abs;
    logic signed [ZW-1:0]  zc;
    logic [13:0] out_c;

    cordic_ctl_t           cctl;
    logic signed [XyW-1:0] cx0, cy0, cx, cy;
    logic signed [ZW-1:0]  cz0, cz;
    logic                  cdone;

    ppws_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cctl),
        .x0      (cx0),
        .y0      (cy0),
        .z0      (cz0),
        .done    (cdone),
        .x       (cx),
        .y       (cy),
        .z       (cz)
    );

    always_comb begin
        count_c  = (32'(cfg.waypoint_count) > MAX_WAYPOINTS) ?
                   7'(MAX_WAYPOINTS) : cfg.waypoint_count;
        slot_ok  = 32'(lidx_reg) < MAX_WAYPOINTS;
        axf      = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ayf      = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        sq_t     = sq_r_reg + sq_bit_reg;
        dist_c   = half_reg ? {sq_r_reg[32:0], 1'b0} : {1'b0, sq_r_reg[32:0]};
        zero_vec = (dx_reg == 33'sd0) && (dy_reg == 33'sd0);
        a_c      = $signed({{2{err_reg[31]}}, err_reg});
        if (a_c > ANG_HPI) begin
            a_c = ANG_PI - a_c;
        end else if (a_c < -ANG_HPI) begin
            a_c = -ANG_PI - a_c;
        end
        s_abs = (cy < 0) ? -cy : cy;
        zc    = cz;
        if (zc < 0) begin
            zc = '0;
        end
        if (zc > ANG_QPI) begin
            zc = ANG_QPI;
        end
        out_c = 14'((zc + 34'sd32768) >>> 16);
        if (out_c > STEER_MAX) begin
            out_c = STEER_MAX;
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_SQX:  begin mul_a = ax_reg;         mul_b = ax_reg;          end
            ST_SQY:  begin mul_a = ay_reg;         mul_b = ay_reg;          end
            ST_NUM:  begin mul_a = cfg.wheel_base; mul_b = {1'b0, mag_reg}; end
            default: begin mul_a = '0;             mul_b = '0;              end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (start) state_next = ST_CHECK;
            ST_CHECK: begin
                if (cmd_reg == CMD_LOAD || cur_reg >= count_c) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:      state_next = ST_ABS;
            ST_ABS:       state_next = ST_SQX;
            ST_SQX:       state_next = ST_SQY;
            ST_SQY:       state_next = ST_SQRT;
            ST_SQRT:      if (cnt_reg == 5'(SqrtSteps - 1)) state_next = ST_ARRIVE;
            ST_ARRIVE: begin
                if (dist_c < 34'(cfg.arrive_radius)) begin
                    state_next = ST_DONE;
                end else if (zero_vec) begin
                    state_next = ST_SINE_GO;
                end else begin
                    state_next = ST_BEAR_GO;
                end
            end
            ST_BEAR_GO:   state_next = ST_BEAR_WAIT;
            ST_BEAR_WAIT: if (cdone) state_next = ST_SINE_GO;
            ST_SINE_GO:   state_next = ST_SINE_WAIT;
            ST_SINE_WAIT: if (cdone) state_next = ST_NUM;
            ST_NUM:       state_next = (mag_reg == '0) ? ST_DONE : ST_DIVCHK;
            ST_DIVCHK: begin
                if (dist_reg == '0 || num_reg >= {dist_reg, 30'b0}) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:       if (cnt_reg == 5'(DivSteps - 1)) state_next = ST_ATAN_GO;
            ST_ATAN_GO:   state_next = ST_ATAN_WAIT;
            ST_ATAN_WAIT: if (cdone) state_next = ST_DONE;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        idle       = (state_reg == ST_IDLE);
        res_valid  = (state_reg == ST_DONE);
        tbl_we     = (state_reg == ST_CHECK) && (cmd_reg == CMD_LOAD) && slot_ok;
        cctl.start = (state_reg == ST_BEAR_GO) || (state_reg == ST_SINE_GO) ||
                     (state_reg == ST_ATAN_GO);
        cctl.mode  = (state_reg == ST_SINE_GO) ? CM_ROTATE : CM_VECTOR;
        cx0 = '0;
        cy0 = '0;
        cz0 = '0;
        unique case (state_reg)
            ST_BEAR_GO: begin
                if (dx_reg[32]) begin
                    cx0 = XyW'(-dx_reg);
                    cy0 = XyW'(-dy_reg);
                    cz0 = ANG_PI;
                end else begin
                    cx0 = XyW'(dx_reg);
                    cy0 = XyW'(dy_reg);
                end
            end
            ST_SINE_GO: begin
                cx0 = CORDIC_K;
                cz0 = a_c;
            end
            ST_ATAN_GO: begin
                cx0 = ONE_Q30;
                cy0 = $signed({6'b0, q_reg});
            end
            default: ;
        endcase
    end

    assign tbl_waddr = AW'(lidx_reg);
    assign tbl_wdata = {ly_reg, lx_reg};
    assign tbl_raddr = AW'(cur_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
            cur_reg   <= '0;
            stop_reg  <= 1'b0;
            adv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && start) begin
                stop_reg <= 1'b0;
                adv_reg  <= 1'b0;
            end
            if (state_reg == ST_CHECK && cmd_reg == CMD_STEP && cur_reg >= count_c) begin
                stop_reg <= 1'b1;
                held_reg <= '0;
            end
            if (state_reg == ST_ARRIVE && dist_c < 34'(cfg.arrive_radius)) begin
                cur_reg <= cur_reg + 7'd1;
                adv_reg <= 1'b1;
            end
            if (state_reg == ST_NUM && mag_reg == '0) begin
                held_reg <= '0;
            end
            if (state_reg == ST_DIVCHK &&
                (dist_reg == '0 || num_reg >= {dist_reg, 30'b0})) begin
                held_reg <= neg_reg ? -15'(STEER_MAX) : 15'(STEER_MAX);
            end
            if (state_reg == ST_ATAN_WAIT && cdone) begin
                held_reg <= neg_reg ? -15'(out_c) : 15'(out_c);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            cmd_reg  <= command;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            head_reg <= heading;
            lidx_reg <= load_index;
            lx_reg   <= load_x;
            ly_reg   <= load_y;
        end
        unique case (state_reg)
            ST_DIFF: begin
                dx_reg <= $signed({tbl_rdata[31], tbl_rdata[31:0]}) -
                          $signed({px_reg[31], px_reg});
                dy_reg <= $signed({tbl_rdata[63], tbl_rdata[63:32]}) -
                          $signed({py_reg[31], py_reg});
            end
            ST_ABS: begin
                half_reg <= (|axf[32:31]) || (|ayf[32:31]);
                ax_reg   <= ((|axf[32:31]) || (|ayf[32:31])) ? axf[32:1] : axf[31:0];
                ay_reg   <= ((|axf[32:31]) || (|ayf[32:31])) ? ayf[32:1] : ayf[31:0];
            end
            ST_SQX: sum_reg <= mul_p;
            ST_SQY: begin
                sq_n_reg   <= sum_reg + mul_p;
                sq_r_reg   <= '0;
                sq_bit_reg <= 64'd1 << 62;
                cnt_reg    <= '0;
            end
            ST_SQRT: begin
                if (sq_n_reg >= sq_t) begin
                    sq_n_reg <= sq_n_reg - sq_t;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg    <= cnt_reg + 5'd1;
            end
            ST_ARRIVE: begin
                dist_reg <= dist_c;
                err_reg  <= 32'd0 - {head_reg, 16'b0};
            end
            ST_BEAR_WAIT: if (cdone) err_reg <= cz[31:0] - {head_reg, 16'b0};
            ST_SINE_WAIT: begin
                if (cdone) begin
                    neg_reg <= cy < 0;
                    mag_reg <= (s_abs > ONE_Q30) ? 31'd1073741824 : 31'(s_abs);
                end
            end
            ST_NUM: num_reg <= {mul_p[62:0], 1'b0};
            ST_DIVCHK: begin
                rem_reg <= num_reg;
                dsh_reg <= {1'b0, dist_reg, 29'b0};
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            ST_DIV: begin
                if (rem_reg >= dsh_reg) begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[28:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[28:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg + 5'd1;
            end
            default: ;
        endcase
    end

    assign res.steering_angle = held_reg;
    assign res.stop           = stop_reg;
    assign res.waypoint_index = cur_reg;
    assign res.advanced       = adv_reg;

endmodule

// File: rtl/pure_pursuit_waypoint_steering_unit.sv
// A load or a step past the end goes straight from the check to the result;
// arrival adds the square root; a full steering step also runs up to three
// CORDIC passes and the divider, all on one sequencer. One item at a time.
// A new item is taken once the core is idle and the output register is empty or being read.
// Reset (aresetn low, synchronous): index and held steering cleared, config
// registers to defaults; the waypoint table keeps its contents.
`timescale 1ns / 1ps

module pure_pursuit_waypoint_steering_unit
    import ppws_pkg::*;
#(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[31:0] pos_y[63:32] heading[79:64] load_index[85:80]
    // load_x[117:86] load_y[149:118]
    input  logic [151:0] s_tdata,
    // command
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // steering_angle[14:0] stop[15] waypoint_index[22:16] advanced[23]
    output logic [23:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

    cfg_t        cfg_reg;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        core_idle, res_valid, start;
    result_t     res;
    logic          tbl_we;
    logic [AW-1:0] tbl_waddr, tbl_raddr;
    logic [63:0]   tbl_wdata, tbl_rdata;

    assign s_tready = core_idle && (!m_tvalid_reg || m_tready);
    assign start    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wheel_base     <= WHEEL_BASE_RST;
            cfg_reg.arrive_radius  <= ARRIVE_RADIUS_RST;
            cfg_reg.waypoint_count <= WP_COUNT_RST;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_WHEEL_BASE:    cfg_reg.wheel_base     <= cfg_wdata;
                REG_ARRIVE_RADIUS: cfg_reg.arrive_radius  <= cfg_wdata;
                REG_WP_COUNT:      cfg_reg.waypoint_count <= cfg_wdata[6:0];
                REG_UNUSED:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= {res.advanced, res.waypoint_index, res.stop, res.steering_angle};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ppws_table #(
        .DEPTH (MAX_WAYPOINTS),
        .AW    (AW)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    ppws_core #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS),
        .AW            (AW)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .command    (s_tuser[0]),
        .pos_x      (s_tdata[31:0]),
        .pos_y      (s_tdata[63:32]),
        .heading    (s_tdata[79:64]),
        .load_index (s_tdata[85:80]),
        .load_x     (s_tdata[117:86]),
        .load_y     (s_tdata[149:118]),
        .cfg        (cfg_reg),
        .idle       (core_idle),
        .res_valid  (res_valid),
        .res        (res),
        .tbl_we     (tbl_we),
        .tbl_waddr  (tbl_waddr),
        .tbl_wdata  (tbl_wdata),
        .tbl_raddr  (tbl_raddr),
        .tbl_rdata  (tbl_rdata)
    );

endmodule

// File: rtl/ppws_checker.sv
// Port-level checks for pure_pursuit_waypoint_steering_unit, bound to it.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module ppws_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [23:0]  m_tdata
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    a_steer_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[14:0]) >= -15'sd8192) &&
                     ($signed(m_tdata[14:0]) <= 15'sd8192))
        else $error("steering out of range");

    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15] |-> (m_tdata[14:0] == 15'd0) && !m_tdata[23])
        else $error("stop with steering or advance");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind pure_pursuit_waypoint_steering_unit ppws_checker u_ppws_checker (.*);
